// ===== rtl/core/afmi_pkg.sv =====
`default_nettype none

package afmi_pkg;

	localparam int unsigned MAX_R_POINTS = 64;
	localparam int unsigned MAX_Z_POINTS = 64;
	localparam int unsigned FIELD_BITS   = 20;

	localparam int unsigned POS_W     = 24;
	localparam int unsigned SPC_W     = 23;
	localparam int unsigned PTS_W     = 7;
	localparam int unsigned LD_IDX_W  = 6;
	localparam int unsigned VAL_W     = 20;
	localparam int unsigned OUT_W     = 20;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_W     = 24;

	localparam int unsigned R_IDX_W = $clog2(MAX_R_POINTS);
	localparam int unsigned Z_IDX_W = $clog2(MAX_Z_POINTS);

	// The table is split over four banks by the parity of both indices, so that
	// the four corners of a cell always fall in four different banks.
	localparam int unsigned BANK_AW    = (R_IDX_W - 1) + (Z_IDX_W - 1);
	localparam int unsigned BANK_DEPTH = 1 << BANK_AW;
	localparam int unsigned RAM_W      = 2 * VAL_W;

	localparam int unsigned SQ_W   = 2 * POS_W - 1;
	localparam int unsigned SUMSQ_W = 2 * POS_W;
	localparam int unsigned FRAC_W = 16;
	localparam int unsigned RAD_W  = SUMSQ_W + FRAC_W;
	localparam int unsigned ROOT_W = RAD_W / 2;
	localparam int unsigned DIV_W  = 41;
	localparam int unsigned QI_W   = DIV_W - FRAC_W;

	localparam int unsigned WGT_W   = FRAC_W + 1;
	localparam int unsigned WPROD_W = 2 * WGT_W;
	localparam int unsigned PROD_W  = WPROD_W + 1 + VAL_W;
	localparam int unsigned SUM_W   = PROD_W + 2;
	localparam int unsigned SAT_W   = 34;

	localparam logic [WGT_W-1:0] ONE_WGT = WGT_W'(1 << FRAC_W);
	localparam logic [PTS_W-1:0] MIN_PTS = PTS_W'(2);
	localparam logic [PTS_W-1:0] MAX_R_PTS = PTS_W'(MAX_R_POINTS);
	localparam logic [PTS_W-1:0] MAX_Z_PTS = PTS_W'(MAX_Z_POINTS);
	localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(64'h8000_0000);
	localparam logic signed [SAT_W-1:0] SAT_LIM = SAT_W'(64'd1 << (FIELD_BITS - 1));

	typedef enum logic {
		CMD_LOAD  = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_R_ORIGIN  = 3'd0,
		CFG_Z_ORIGIN  = 3'd1,
		CFG_R_SPACING = 3'd2,
		CFG_Z_SPACING = 3'd3,
		CFG_R_POINTS  = 3'd4,
		CFG_Z_POINTS  = 3'd5
	} cfg_reg_t;

	// What travels alongside an item through the root and division pipelines.
	typedef struct packed {
		cmd_t                cmd;
		logic                neg;
		logic [POS_W-1:0]    az;
		logic [LD_IDX_W-1:0] load_r_index;
		logic [LD_IDX_W-1:0] load_z_index;
		logic [VAL_W-1:0]    load_radial_value;
		logic [VAL_W-1:0]    load_axial_value;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/core/afmi_ram.sv =====
`default_nettype none

module afmi_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/afmi_sqrt.sv =====
`default_nettype none

module afmi_sqrt import afmi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_i,
	input  side_t             side_i,
	input  logic [RAD_W-1:0]  rad_i,
	output logic              vld_o,
	output side_t             side_o,
	output logic [ROOT_W-1:0] root_o
);

	logic              vld_s  [ROOT_W];
	side_t             side_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [ROOT_W+1:0] rem_s  [ROOT_W];

	// One result bit per stage, two radicand bits brought down each time.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic              vld_in;
		side_t             side_in;
		logic [RAD_W-1:0]  rad_in;
		logic [ROOT_W-1:0] root_in;
		logic [ROOT_W+1:0] rem_in;
		logic [ROOT_W+3:0] acc;
		logic [ROOT_W+3:0] trial;
		logic              ge;
		logic [ROOT_W+1:0] rem_nx;
		logic [ROOT_W-1:0] root_nx;

		if (k == 0) begin : g_first
			assign vld_in  = vld_i;
			assign side_in = side_i;
			assign rad_in  = rad_i;
			assign root_in = '0;
			assign rem_in  = '0;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign side_in = side_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign rem_in  = rem_s[k-1];
		end

		always_comb begin
			acc     = {rem_in, rad_in[RAD_W-1-2*k -: 2]};
			trial   = {2'b00, root_in, 2'b01};
			ge      = acc >= trial;
			rem_nx  = ge ? (ROOT_W+2)'(acc - trial) : acc[ROOT_W+1:0];
			root_nx = {root_in[ROOT_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k] <= side_in;
				rad_s[k]  <= rad_in;
				root_s[k] <= root_nx;
				rem_s[k]  <= rem_nx;
			end
		end
	end

	assign vld_o  = vld_s[ROOT_W-1];
	assign side_o = side_s[ROOT_W-1];
	assign root_o = root_s[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/afmi_div.sv =====
`default_nettype none

module afmi_div import afmi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             vld_i,
	input  side_t            side_i,
	input  logic [DIV_W-1:0] dr_i,
	input  logic [DIV_W-1:0] dz_i,
	input  logic [SPC_W-1:0] sr_i,
	input  logic [SPC_W-1:0] sz_i,
	output logic             vld_o,
	output side_t            side_o,
	output logic [DIV_W-1:0] qr_o,
	output logic [DIV_W-1:0] qz_o
);

	logic             vld_s  [DIV_W];
	side_t            side_s [DIV_W];
	logic [DIV_W-1:0] dr_s   [DIV_W];
	logic [DIV_W-1:0] dz_s   [DIV_W];
	logic [DIV_W-1:0] qr_s   [DIV_W];
	logic [DIV_W-1:0] qz_s   [DIV_W];
	logic [SPC_W-1:0] remr_s [DIV_W];
	logic [SPC_W-1:0] remz_s [DIV_W];

	// Restoring division of both coordinates side by side, one quotient bit per
	// stage. The divisors are the spacing registers, which the user must keep steady while items flow.
	for (genvar i = 0; i < DIV_W; i++) begin : g_stage
		localparam int unsigned Pos = DIV_W - 1 - i;
		logic             vld_in;
		side_t            side_in;
		logic [DIV_W-1:0] dr_in, dz_in, qr_in, qz_in;
		logic [SPC_W-1:0] remr_in, remz_in;
		logic [SPC_W:0]   acc_r, acc_z;
		logic             ge_r, ge_z;
		logic [SPC_W-1:0] remr_nx, remz_nx;
		logic [DIV_W-1:0] qr_nx, qz_nx;

		if (i == 0) begin : g_first
			assign vld_in  = vld_i;
			assign side_in = side_i;
			assign dr_in   = dr_i;
			assign dz_in   = dz_i;
			assign qr_in   = '0;
			assign qz_in   = '0;
			assign remr_in = '0;
			assign remz_in = '0;
		end else begin : g_next
			assign vld_in  = vld_s[i-1];
			assign side_in = side_s[i-1];
			assign dr_in   = dr_s[i-1];
			assign dz_in   = dz_s[i-1];
			assign qr_in   = qr_s[i-1];
			assign qz_in   = qz_s[i-1];
			assign remr_in = remr_s[i-1];
			assign remz_in = remz_s[i-1];
		end

		always_comb begin
			acc_r   = {remr_in, dr_in[Pos]};
			acc_z   = {remz_in, dz_in[Pos]};
			ge_r    = acc_r >= {1'b0, sr_i};
			ge_z    = acc_z >= {1'b0, sz_i};
			remr_nx = ge_r ? SPC_W'(acc_r - {1'b0, sr_i}) : acc_r[SPC_W-1:0];
			remz_nx = ge_z ? SPC_W'(acc_z - {1'b0, sz_i}) : acc_z[SPC_W-1:0];
			qr_nx      = qr_in;
			qr_nx[Pos] = ge_r;
			qz_nx      = qz_in;
			qz_nx[Pos] = ge_z;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= side_in;
				dr_s[i]   <= dr_in;
				dz_s[i]   <= dz_in;
				qr_s[i]   <= qr_nx;
				qz_s[i]   <= qz_nx;
				remr_s[i] <= remr_nx;
				remz_s[i] <= remz_nx;
			end
		end
	end

	assign vld_o  = vld_s[DIV_W-1];
	assign side_o = side_s[DIV_W-1];
	assign qr_o   = qr_s[DIV_W-1];
	assign qz_o   = qz_s[DIV_W-1];

endmodule

`default_nettype wire

// ===== rtl/core/axisymmetric_field_map_interp.sv =====
// Field map lookup for an axisymmetric magnet, bilinear in radius and |z|.
// Request channel (req_valid / req_stall): command selects a load beat, which
// writes one grid point of the radial and axial tables, or a query beat, which
// gives a point x, y, z. Only queries produce a response beat on the response
// channel (rsp_valid / rsp_stall) carrying b_y, b_z and beyond_radius; loads
// and queries keep their order, so a query sees every load accepted before it.
// Configuration registers (origins, spacings, point counts) are written through
// cfg_we / cfg_index / cfg_data; the user must write them only while no beat
// is in flight, as the block does not enforce this. Throughput is one beat per
// cycle while no response is stalled. A query passes through squaring, the sum
// of squares, the square root pipeline, the origin offset, the cell divider,
// table read, weighting, summing and rounding into the output register.
// Reset clears the pipeline valids and the configuration to its defaults; the
// tables are not cleared and must be loaded before they are queried.
// When the receiver stalls a waiting response, the whole pipeline holds and
// req_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none

module axisymmetric_field_map_interp import afmi_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     command,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [LD_IDX_W-1:0]      load_r_index,
	input  logic [LD_IDX_W-1:0]      load_z_index,
	input  logic signed [VAL_W-1:0]  load_radial_value,
	input  logic signed [VAL_W-1:0]  load_axial_value,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [OUT_W-1:0]  b_y,
	output logic signed [OUT_W-1:0]  b_z,
	output logic                     beyond_radius,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data
);

	function automatic logic [OUT_W-1:0] round_sat(input logic [SUM_W-1:0] mag,
			input logic sgn);
		logic [SUM_W-1:0]         rnd;
		logic signed [SAT_W-1:0]  m;
		logic signed [SAT_W-1:0]  v;
		rnd = mag + RND_HALF;
		m   = SAT_W'(rnd[SUM_W-1:32]);
		if (sgn) begin
			v = (m > SAT_LIM) ? -SAT_LIM : -m;
		end else begin
			v = (m > SAT_LIM - 1) ? SAT_LIM - 1 : m;
		end
		return v[OUT_W-1:0];
	endfunction

	logic adv;

	// Configuration registers.
	logic [POS_W-1:0] r_origin_q, z_origin_q;
	logic [SPC_W-1:0] r_spacing_q, z_spacing_q;
	logic [PTS_W-1:0] r_points_q, z_points_q;
	logic [SPC_W-1:0] r_step, z_step;
	logic [PTS_W-1:0] rp, zp, rp_m1, zp_m1, zp_m2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_origin_q  <= '0;
			z_origin_q  <= '0;
			r_spacing_q <= SPC_W'(256);
			z_spacing_q <= SPC_W'(256);
			r_points_q  <= PTS_W'(64);
			z_points_q  <= PTS_W'(64);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_R_ORIGIN:  r_origin_q  <= cfg_data;
				CFG_Z_ORIGIN:  z_origin_q  <= cfg_data;
				CFG_R_SPACING: r_spacing_q <= cfg_data[SPC_W-1:0];
				CFG_Z_SPACING: z_spacing_q <= cfg_data[SPC_W-1:0];
				CFG_R_POINTS:  r_points_q  <= cfg_data[PTS_W-1:0];
				CFG_Z_POINTS:  z_points_q  <= cfg_data[PTS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		r_step = (r_spacing_q == '0) ? SPC_W'(1) : r_spacing_q;
		z_step = (z_spacing_q == '0) ? SPC_W'(1) : z_spacing_q;
		rp = (r_points_q < MIN_PTS) ? MIN_PTS :
			(r_points_q > MAX_R_PTS) ? MAX_R_PTS : r_points_q;
		zp = (z_points_q < MIN_PTS) ? MIN_PTS :
			(z_points_q > MAX_Z_PTS) ? MAX_Z_PTS : z_points_q;
		rp_m1 = rp - PTS_W'(1);
		zp_m1 = zp - PTS_W'(1);
		zp_m2 = zp - PTS_W'(2);
	end

	// The whole pipeline moves unless a finished response is held up.
	assign adv       = !rsp_valid || !rsp_stall;
	assign req_stall = !adv;

	// Stage 1: squares, |z| and the sign of the radial component.
	logic                     vld_s1;
	side_t                    side_s1;
	logic [SQ_W-1:0]          xsq_s1, ysq_s1;
	logic signed [2*POS_W-1:0] xsq_full, ysq_full;
	side_t                    side_in;

	assign xsq_full = pos_x * pos_x;
	assign ysq_full = pos_y * pos_y;

	always_comb begin
		side_in.cmd  = cmd_t'(command);
		side_in.neg  = (pos_y < 0 && pos_z > 0) || (pos_y > 0 && pos_z < 0);
		side_in.az   = pos_z[POS_W-1] ? POS_W'(-pos_z) : POS_W'(pos_z);
		side_in.load_r_index      = load_r_index;
		side_in.load_z_index      = load_z_index;
		side_in.load_radial_value = load_radial_value;
		side_in.load_axial_value  = load_axial_value;
	end

	// Stage 2: sum of squares.
	logic                vld_s2;
	side_t               side_s2;
	logic [SUMSQ_W-1:0]  sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= side_in;
			xsq_s1  <= xsq_full[SQ_W-1:0];
			ysq_s1  <= ysq_full[SQ_W-1:0];
			side_s2 <= side_s1;
			sum_s2  <= {1'b0, xsq_s1} + {1'b0, ysq_s1};
		end
	end

	logic              sq_vld;
	side_t             sq_side;
	logic [ROOT_W-1:0] sq_root;

	afmi_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s2),
		.side_i (side_s2),
		.rad_i  ({sum_s2, FRAC_W'(0)}),
		.vld_o  (sq_vld),
		.side_o (sq_side),
		.root_o (sq_root)
	);

	// Stage 3: distances from the grid origin, scaled as dividends.
	logic               vld_s3;
	side_t              side_s3;
	logic [DIV_W-1:0]   dr_s3, dz_s3;
	logic signed [34:0] dr_diff;
	logic signed [25:0] dz_diff;

	always_comb begin
		dr_diff = $signed({3'b000, sq_root})
			- $signed({{3{r_origin_q[POS_W-1]}}, r_origin_q, 8'h00});
		dz_diff = $signed({2'b00, sq_side.az})
			- $signed({{2{z_origin_q[POS_W-1]}}, z_origin_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sq_vld;
		end
	end

	// Below the origin the dividend is zero: index 0, weight 0.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= sq_side;
			dr_s3   <= dr_diff[34] ? '0 : {dr_diff[32:0], 8'h00};
			dz_s3   <= dz_diff[25] ? '0 : {dz_diff[24:0], FRAC_W'(0)};
		end
	end

	logic             dv_vld;
	side_t            dv_side;
	logic [DIV_W-1:0] dv_qr, dv_qz;

	afmi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (vld_s3),
		.side_i (side_s3),
		.dr_i   (dr_s3),
		.dz_i   (dz_s3),
		.sr_i   (r_step),
		.sz_i   (z_step),
		.vld_o  (dv_vld),
		.side_o (dv_side),
		.qr_o   (dv_qr),
		.qz_o   (dv_qz)
	);

	// Stage 4: cell indices and weights, with the edge cases of the grid.
	logic               vld_s4;
	side_t              side_s4;
	logic [R_IDX_W-1:0] ri_s4;
	logic [Z_IDX_W-1:0] zi_s4;
	logic [WGT_W-1:0]   wr_s4, wz_s4;
	logic               beyond_s4;
	logic               r_past, z_past;

	always_comb begin
		r_past = dv_qr[DIV_W-1:FRAC_W] >= QI_W'(rp_m1);
		z_past = dv_qz[DIV_W-1:FRAC_W] >= QI_W'(zp_m1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4   <= dv_side;
			beyond_s4 <= r_past;
			ri_s4     <= r_past ? R_IDX_W'(rp_m1) : dv_qr[FRAC_W +: R_IDX_W];
			wr_s4     <= r_past ? '0 : {1'b0, dv_qr[FRAC_W-1:0]};
			zi_s4     <= z_past ? Z_IDX_W'(zp_m2) : dv_qz[FRAC_W +: Z_IDX_W];
			wz_s4     <= z_past ? ONE_WGT : {1'b0, dv_qz[FRAC_W-1:0]};
		end
	end

	// Stage 5: table read in four banks, table write for load beats, weights.
	logic               ld_en;
	logic [1:0]         ld_bank;
	logic [BANK_AW-1:0] ld_addr;
	logic [R_IDX_W-1:0] ld_r;
	logic [Z_IDX_W-1:0] ld_z;
	logic [RAM_W-1:0]   bank_rd [4];

	always_comb begin
		ld_r    = R_IDX_W'(side_s4.load_r_index);
		ld_z    = Z_IDX_W'(side_s4.load_z_index);
		ld_en   = adv && vld_s4 && side_s4.cmd == CMD_LOAD
			&& PTS_W'(side_s4.load_r_index) < MAX_R_PTS
			&& PTS_W'(side_s4.load_z_index) < MAX_Z_PTS;
		ld_bank = {ld_z[0], ld_r[0]};
		ld_addr = {ld_z[Z_IDX_W-1:1], ld_r[R_IDX_W-1:1]};
	end

	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic [1:0] Bank = 2'(b);
		logic [Z_IDX_W-1:0] zsel;
		logic [R_IDX_W-1:0] rsel;

		always_comb begin
			zsel = (zi_s4[0] == Bank[1]) ? zi_s4 : zi_s4 + Z_IDX_W'(1);
			rsel = (ri_s4[0] == Bank[0]) ? ri_s4 : ri_s4 + R_IDX_W'(1);
		end

		afmi_ram #(
			.WIDTH (RAM_W),
			.DEPTH (BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (ld_en && ld_bank == Bank),
			.waddr (ld_addr),
			.wdata ({side_s4.load_radial_value, side_s4.load_axial_value}),
			.re    (adv),
			.raddr ({zsel[Z_IDX_W-1:1], rsel[R_IDX_W-1:1]}),
			.rdata (bank_rd[b])
		);
	end

	logic               qv_s5, neg_s5, beyond_s5, ri0_s5, zi0_s5;
	logic [WPROD_W-1:0] wgt_s5 [4];
	logic [WGT_W-1:0]   omr, omz;

	always_comb begin
		omr = ONE_WGT - wr_s4;
		omz = ONE_WGT - wz_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s5 <= 1'b0;
		end else if (adv) begin
			qv_s5 <= vld_s4 && side_s4.cmd == CMD_QUERY;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s5    <= side_s4.neg;
			beyond_s5 <= beyond_s4;
			ri0_s5    <= ri_s4[0];
			zi0_s5    <= zi_s4[0];
			wgt_s5[0] <= omz * omr;
			wgt_s5[1] <= omz * wr_s4;
			wgt_s5[2] <= wz_s4 * omr;
			wgt_s5[3] <= wz_s4 * wr_s4;
		end
	end

	// Stage 6: route banks to corners and weight them. Past the last radius
	// the upper-radius corners repeat the edge column with zero weight.
	logic                     qv_s6, neg_s6, beyond_s6;
	logic signed [PROD_W-1:0] prod_r_s6 [4];
	logic signed [PROD_W-1:0] prod_a_s6 [4];

	for (genvar c = 0; c < 4; c++) begin : g_corner
		localparam logic [1:0] Corner = 2'(c);
		logic [1:0]              bsel;
		logic [RAM_W-1:0]        word;
		logic signed [VAL_W-1:0] rad_v, ax_v;

		always_comb begin
			bsel  = {zi0_s5 ^ Corner[1], ri0_s5 ^ (Corner[0] & ~beyond_s5)};
			word  = bank_rd[bsel];
			rad_v = word[RAM_W-1:VAL_W];
			ax_v  = word[VAL_W-1:0];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_r_s6[c] <= $signed({1'b0, wgt_s5[c]}) * rad_v;
				prod_a_s6[c] <= $signed({1'b0, wgt_s5[c]}) * ax_v;
			end
		end
	end

	// Stage 7: sums. Stage 8: magnitude and final sign.
	logic                    qv_s7, neg_s7, beyond_s7;
	logic signed [SUM_W-1:0] sum_r_s7, sum_a_s7;
	logic                    qv_s8, beyond_s8, sgn_y_s8, sgn_z_s8;
	logic [SUM_W-1:0]        mag_y_s8, mag_z_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s6     <= 1'b0;
			qv_s7     <= 1'b0;
			qv_s8     <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (adv) begin
			qv_s6     <= qv_s5;
			qv_s7     <= qv_s6;
			qv_s8     <= qv_s7;
			rsp_valid <= qv_s8;
		end
	end

	// Rounding is symmetric about zero, so the sign flip is applied to the
	// rounded magnitude.
	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s6    <= neg_s5;
			beyond_s6 <= beyond_s5;
			neg_s7    <= neg_s6;
			beyond_s7 <= beyond_s6;
			sum_r_s7  <= prod_r_s6[0] + prod_r_s6[1] + prod_r_s6[2] + prod_r_s6[3];
			sum_a_s7  <= prod_a_s6[0] + prod_a_s6[1] + prod_a_s6[2] + prod_a_s6[3];
			beyond_s8 <= beyond_s7;
			sgn_y_s8  <= sum_r_s7[SUM_W-1] ^ neg_s7;
			sgn_z_s8  <= sum_a_s7[SUM_W-1];
			mag_y_s8  <= sum_r_s7[SUM_W-1] ? SUM_W'(-sum_r_s7) : SUM_W'(sum_r_s7);
			mag_z_s8  <= sum_a_s7[SUM_W-1] ? SUM_W'(-sum_a_s7) : SUM_W'(sum_a_s7);
			b_y           <= round_sat(mag_y_s8, sgn_y_s8);
			b_z           <= round_sat(mag_z_s8, sgn_z_s8);
			beyond_radius <= beyond_s8;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/afmi_chk.sv =====
`default_nettype none

module afmi_chk import afmi_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_stall,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic signed [OUT_W-1:0] b_y,
	input logic signed [OUT_W-1:0] b_z,
	input logic                    beyond_radius
);

	// A held response keeps its beat.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(b_y) && $stable(b_z)
			&& $stable(beyond_radius))
		else $error("response beat changed while stalled");

	// Back-pressure reaches the request side in the same cycle.
	a_stall_through: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request accepted while response is stalled");

	// The block never stalls requests on its own account.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a held response");

	// Reset leaves no response pending.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid straight after reset");

endmodule

bind axisymmetric_field_map_interp afmi_chk u_afmi_chk (.*);

`default_nettype wire

// ===== tb/sv/afmi_field_checker.sv =====
`default_nettype none

module afmi_field_checker import afmi_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    req_valid,
	input  logic                    req_stall,
	input  logic                    command,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [LD_IDX_W-1:0]     load_r_index,
	input  logic [LD_IDX_W-1:0]     load_z_index,
	input  logic signed [VAL_W-1:0] load_radial_value,
	input  logic signed [VAL_W-1:0] load_axial_value,
	input  logic                    rsp_valid,
	input  logic                    rsp_stall,
	input  logic signed [OUT_W-1:0] b_y,
	input  logic signed [OUT_W-1:0] b_z,
	input  logic                    beyond_radius,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	output int                      fails,
	output int                      pending
);

	localparam longint ONE_W = 64'd65536;
	localparam int TAB_DEPTH = MAX_R_POINTS * MAX_Z_POINTS;

	typedef struct {
		logic signed [OUT_W-1:0] fy;
		logic signed [OUT_W-1:0] fz;
		logic                    past_edge;
	} field_t;

	logic signed [VAL_W-1:0] radial_tab [TAB_DEPTH];
	logic signed [VAL_W-1:0] axial_tab [TAB_DEPTH];
	logic signed [POS_W-1:0] r_org, z_org;
	logic [SPC_W-1:0]        r_spc, z_spc;
	logic [PTS_W-1:0]        r_pts, z_pts;
	field_t                  field_q [$];

	initial fails = 0;

	task automatic note_mismatch(input string msg);
		$display("mismatch: %s", msg);
		fails++;
	endtask

	function automatic longint unsigned int_root(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic int clamp_pts(input logic [PTS_W-1:0] p, input int maxp);
		if (p < 2) return 2;
		if (p > maxp) return maxp;
		return int'(p);
	endfunction

	// Finds the cell of a position in 1/256 of a coordinate unit; returns 1 at or past the last point.
	function automatic bit find_cell(input longint pos, input logic signed [POS_W-1:0] org,
			input logic [SPC_W-1:0] spc, input int pts, output int idx, output longint w);
		longint d, step, q;
		d = pos - longint'(org) * 256;
		step = (spc == 0 ? 64'd1 : longint'(spc)) * 256;
		if (d < 0) begin
			idx = 0;
			w = 0;
			return 0;
		end
		q = d / step;
		if (q >= pts - 1) begin
			idx = pts - 1;
			w = ONE_W;
			return 1;
		end
		idx = int'(q);
		w = ((d % step) << 16) / step;
		return 0;
	endfunction

	function automatic logic signed [OUT_W-1:0] round_field(input longint s);
		longint v, lim;
		lim = longint'(1) << (FIELD_BITS - 1);
		if (s >= 0) v = (s + 64'h8000_0000) >>> 32;
		else v = -((-s + 64'h8000_0000) >>> 32);
		if (v > lim - 1) v = lim - 1;
		if (v < -lim) v = -lim;
		return OUT_W'(v);
	endfunction

	function automatic field_t interp_field(input logic signed [POS_W-1:0] px,
			input logic signed [POS_W-1:0] py, input logic signed [POS_W-1:0] pz);
		field_t res;
		longint x, y, z, az, rfix, wr, wz, sr, sa;
		longint wgt [4];
		int addr [4];
		int rp, zp, ri, zi, ri1, zi1;
		bit past_r;
		x = longint'(px);
		y = longint'(py);
		z = longint'(pz);
		az = z < 0 ? -z : z;
		rp = clamp_pts(r_pts, MAX_R_POINTS);
		zp = clamp_pts(z_pts, MAX_Z_POINTS);
		rfix = longint'(int_root(longint'(unsigned'(x * x + y * y)) << 16));
		past_r = find_cell(rfix, r_org, r_spc, rp, ri, wr);
		if (past_r) begin
			wr = 0;
			ri1 = ri;
		end else begin
			ri1 = ri + 1;
		end
		if (find_cell(az * 256, z_org, z_spc, zp, zi, wz)) zi = zp - 2;
		zi1 = zi + 1;
		wgt[0] = (ONE_W - wz) * (ONE_W - wr);
		wgt[1] = (ONE_W - wz) * wr;
		wgt[2] = wz * (ONE_W - wr);
		wgt[3] = wz * wr;
		addr[0] = zi * MAX_R_POINTS + ri;
		addr[1] = zi * MAX_R_POINTS + ri1;
		addr[2] = zi1 * MAX_R_POINTS + ri;
		addr[3] = zi1 * MAX_R_POINTS + ri1;
		sr = 0;
		sa = 0;
		for (int k = 0; k < 4; k++) begin
			sr += wgt[k] * longint'(radial_tab[addr[k] % TAB_DEPTH]);
			sa += wgt[k] * longint'(axial_tab[addr[k] % TAB_DEPTH]);
		end
		if ((y < 0 && z > 0) || (y > 0 && z < 0)) sr = -sr;
		res.fy = round_field(sr);
		res.fz = round_field(sa);
		res.past_edge = past_r;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_t want;
		if (!arst_n) begin
			r_org = '0;
			z_org = '0;
			r_spc = SPC_W'(256);
			z_spc = SPC_W'(256);
			r_pts = MAX_R_PTS;
			z_pts = MAX_Z_PTS;
			field_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					CFG_R_ORIGIN:  r_org = cfg_data[POS_W-1:0];
					CFG_Z_ORIGIN:  z_org = cfg_data[POS_W-1:0];
					CFG_R_SPACING: r_spc = cfg_data[SPC_W-1:0];
					CFG_Z_SPACING: z_spc = cfg_data[SPC_W-1:0];
					CFG_R_POINTS:  r_pts = cfg_data[PTS_W-1:0];
					CFG_Z_POINTS:  z_pts = cfg_data[PTS_W-1:0];
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				if (cmd_t'(command) == CMD_QUERY) begin
					field_q.push_back(interp_field(pos_x, pos_y, pos_z));
				end else begin
					radial_tab[load_z_index * MAX_R_POINTS + load_r_index] = load_radial_value;
					axial_tab[load_z_index * MAX_R_POINTS + load_r_index] = load_axial_value;
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (field_q.size() == 0) begin
					note_mismatch("response beat with no query waiting");
				end else begin
					want = field_q.pop_front();
					if (b_y !== want.fy)
						note_mismatch($sformatf("b_y %0d, expected %0d", b_y, want.fy));
					if (b_z !== want.fz)
						note_mismatch($sformatf("b_z %0d, expected %0d", b_z, want.fz));
					if (beyond_radius !== want.past_edge)
						note_mismatch($sformatf("beyond_radius %b, expected %b",
							beyond_radius, want.past_edge));
				end
			end
			pending <= field_q.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/sv/axisymmetric_field_map_interp_tb.sv =====
`default_nettype none

module axisymmetric_field_map_interp_tb import afmi_pkg::*; ();

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 100;
	localparam int FILL_PTS = 32;
	localparam int STALL_NONE = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	localparam int STALL_PERIODIC = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic command = 1'b0;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic [LD_IDX_W-1:0] load_r_index = '0, load_z_index = '0;
	logic signed [VAL_W-1:0] load_radial_value = '0, load_axial_value = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic signed [OUT_W-1:0] b_y, b_z;
	logic beyond_radius;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	int fails, pending;

	int burst_left = 0;
	int stall_mode = STALL_NONE;
	int stall_left = 0;
	int stall_tick = 0;
	int quiet = 0;
	longint r_lim, z_lim;

	always #5 clk = ~clk;

	axisymmetric_field_map_interp dut (.*);

	afmi_field_checker checker_i (.*);

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_PERIODIC);
			stall_left = $urandom_range(20, 300);
		end else begin
			stall_left--;
		end
		stall_tick++;
		case (stall_mode)
			STALL_LIGHT:    rsp_stall = ($urandom_range(0, 3) == 0);
			STALL_HEAVY:    rsp_stall = ($urandom_range(0, 9) != 0);
			STALL_PERIODIC: rsp_stall = (stall_tick % 5 < 2);
			default:        rsp_stall = 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("** axisymmetric_field_map_interp: FAILED **");
			$finish;
		end
	end

	task automatic send(input cmd_t cmd, input logic signed [POS_W-1:0] x,
			input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z,
			input int ri, input int zi, input logic signed [VAL_W-1:0] rv,
			input logic signed [VAL_W-1:0] av);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid = 1'b1;
		command = cmd;
		pos_x = x;
		pos_y = y;
		pos_z = z;
		load_r_index = LD_IDX_W'(ri);
		load_z_index = LD_IDX_W'(zi);
		load_radial_value = rv;
		load_axial_value = av;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic load_point(input int ri, input int zi, input logic signed [VAL_W-1:0] rv,
			input logic signed [VAL_W-1:0] av);
		send(CMD_LOAD, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom), ri, zi, rv, av);
	endtask

	task automatic query_point(input logic signed [POS_W-1:0] x,
			input logic signed [POS_W-1:0] y, input logic signed [POS_W-1:0] z);
		send(CMD_QUERY, x, y, z, $urandom_range(0, 63), $urandom_range(0, 63),
			VAL_W'($urandom), VAL_W'($urandom));
	endtask

	task automatic drain;
		@(negedge clk);
		req_valid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(input logic signed [POS_W-1:0] ro, input logic signed [POS_W-1:0] zo,
			input int rs, input int zs, input int rp, input int zp);
		cfg_reg_t idx [6];
		logic [CFG_W-1:0] val [6];
		drain();
		idx = '{CFG_R_ORIGIN, CFG_Z_ORIGIN, CFG_R_SPACING, CFG_Z_SPACING, CFG_R_POINTS,
			CFG_Z_POINTS};
		val = '{ro, zo, CFG_W'(rs), CFG_W'(zs), CFG_W'(rp), CFG_W'(zp)};
		for (int k = 0; k < 6; k++) begin
			@(negedge clk);
			cfg_we = 1'b1;
			cfg_index = idx[k];
			cfg_data = val[k];
		end
		@(negedge clk);
		cfg_we = 1'b0;
		r_lim = (ro < 0 ? -longint'(ro) : longint'(ro)) + longint'(rs) * (rp + 1);
		z_lim = (zo < 0 ? -longint'(zo) : longint'(zo)) + longint'(zs) * (zp + 1);
		if (r_lim > 8388607) r_lim = 8388607;
		if (z_lim > 8388607) z_lim = 8388607;
	endtask

	function automatic logic signed [POS_W-1:0] pick_coord(input longint lim);
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7) return POS_W'(longint'($urandom_range(0, 2 * lim)) - lim);
		if (sel < 9) return POS_W'($urandom);
		return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value;
		case ($urandom_range(0, 9))
			0:       return 20'sh7FFFF;
			1:       return 20'sh80000;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	task automatic random_items(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3)
				load_point($urandom_range(0, 63), $urandom_range(0, 63), pick_value(),
					pick_value());
			else
				query_point(pick_coord(r_lim), pick_coord(r_lim), pick_coord(z_lim));
		end
	endtask

	initial begin
		r_lim = 64 * 256;
		z_lim = 64 * 256;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every grid point in use is written once so that no query reads an empty entry.
		set_grid(0, 0, 256, 256, FILL_PTS, FILL_PTS);
		for (int zi = 0; zi < FILL_PTS; zi++)
			for (int ri = 0; ri < FILL_PTS; ri++)
				load_point(ri, zi, pick_value(), pick_value());

		// A cell full of the most negative radial value: the sign flip must saturate.
		load_point(0, 0, 20'sh80000, 20'sh7FFFF);
		load_point(1, 0, 20'sh80000, 20'sh7FFFF);
		load_point(0, 1, 20'sh80000, 20'sh80000);
		load_point(1, 1, 20'sh80000, 20'sh80000);
		query_point(0, -1, 1);
		query_point(0, 1, -1);
		query_point(0, 0, 0);
		query_point(0, -1, 0);
		query_point(0, 0, -200);
		query_point(300, -50, 100);
		query_point(300, 50, -100);
		query_point(POS_W'((FILL_PTS - 1) * 256), 0, 0);
		query_point(POS_W'((FILL_PTS - 1) * 256 + 1), 0, 5000);
		query_point(0, 0, POS_W'((FILL_PTS - 1) * 256));
		query_point(0, 0, POS_W'(-((FILL_PTS - 1) * 256 + 700)));
		query_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
		query_point(24'sh800000, 24'sh800000, 24'sh800000);
		load_point(FILL_PTS - 1, FILL_PTS - 1, 20'sh7FFFF, 20'sh80000);
		query_point(20000, 0, -20000);
		random_items(120);

		set_grid(0, 0, 1, 1, 2, 2);
		query_point(1, 0, 1);
		query_point(0, 1, -1);
		random_items(100);

		set_grid(24'sh800000, 24'sh7FFFFF, 8388607, 8388607, FILL_PTS, FILL_PTS);
		random_items(100);

		set_grid(2000, 1500, 100, 300, 17, 30);
		query_point(0, 0, 0);
		random_items(120);

		// Pause the sender until all queries have answered, then carry on unchanged.
		drain();
		random_items(40);

		for (int ph = 0; ph < 4; ph++) begin
			set_grid(POS_W'(int'($urandom_range(0, 8192)) - 4096),
				POS_W'(int'($urandom_range(0, 8192)) - 4096),
				$urandom_range(16, 2000), $urandom_range(16, 2000),
				$urandom_range(2, FILL_PTS), $urandom_range(2, FILL_PTS));
			random_items(100);
		end

		set_grid(0, 0, 256, 256, FILL_PTS, FILL_PTS);
		random_items(30);

		drain();
		if (fails == 0 && pending == 0) begin
			$display("** axisymmetric_field_map_interp: PASSED **");
		end else begin
			$display("** axisymmetric_field_map_interp: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/afmi_pkg.sv
rtl/core/afmi_ram.sv
rtl/core/afmi_sqrt.sv
rtl/core/afmi_div.sv
rtl/core/axisymmetric_field_map_interp.sv
rtl/core/afmi_chk.sv
tb/sv/afmi_field_checker.sv
tb/sv/axisymmetric_field_map_interp_tb.sv
